[sv/tlc_pkg.sv]
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, codes and constants of the two-level write-back cache.
// ----------------------------------------------------------------------------
package tlc_pkg;

   localparam int ADDR_BITS       = 20;
   localparam int WORD_BYTES      = 4;
   localparam int DATA_W          = 32;
   localparam int TIME_W          = 32;
   localparam int COST_W          = 10;
   localparam int NUM_COSTS       = 6;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam int L1_LINES_DEF    = 256;
   localparam int L2_SETS_DEF     = 512;
   localparam int BLOCK_BYTES_DEF = 64;

   typedef enum logic [2:0] {
      COST_L1_RD   = 3'd0,
      COST_L1_WR   = 3'd1,
      COST_L2_RD   = 3'd2,
      COST_L2_WR   = 3'd3,
      COST_MAIN_RD = 3'd4,
      COST_MAIN_WR = 3'd5
   } cost_sel_type;

   typedef logic [NUM_COSTS-1:0][COST_W-1:0] cost_vec_type;

   localparam cost_vec_type COST_RESET = {
      10'd100, 10'd100, 10'd4, 10'd4, 10'd1, 10'd1
   };

   typedef struct packed {
      logic                 mode;
      logic [ADDR_BITS-1:0] address;
      logic [DATA_W-1:0]    write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              l1_hit;
      logic              l2_hit;
      logic [TIME_W-1:0] elapsed_time;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_L1_CHK,
      ST_L2_LOOK,
      ST_L2_CHK,
      ST_L2_EVICT,
      ST_L2_FETCH,
      ST_L2_XFER,
      ST_L2_DONE,
      ST_ACC,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CP_EVICT,
      CP_FETCH,
      CP_WB,
      CP_FILL
   } copy_kind_type;

   typedef struct packed {
      logic          clr;
      logic          accept;
      logic          l2_look;
      logic          l2_wr;
      logic          l2_chk;
      logic          copy;
      copy_kind_type copy_kind;
      logic          add_cost;
      cost_sel_type  cost_sel;
      logic          l2_fill_meta;
      logic          l2_done;
      logic          acc;
      logic          finish;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic mode;
      logic l1_hit;
      logic l1_vdirty;
      logic l2_hit;
      logic l2_vdirty;
      logic copy_last;
      logic rsp_free;
   } status_type;

endpackage

[sv/tlc_csr.sv]
// ----------------------------------------------------------------------------
// tlc_csr
// Cost registers behind the register port.
// ----------------------------------------------------------------------------
module tlc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tlc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tlc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tlc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output tlc_pkg::cost_vec_type            costs
);

   localparam int IW = tlc_pkg::CSR_ADDR_W - 2;

   tlc_pkg::cost_vec_type cost_ff;
   logic [IW-1:0]         idx;
   logic                  idx_ok;

   assign idx    = paddr[tlc_pkg::CSR_ADDR_W-1:2];
   assign idx_ok = idx < IW'(tlc_pkg::NUM_COSTS);
   assign pready = 1'b1;
   assign costs  = cost_ff;
   assign prdata = idx_ok ? tlc_pkg::CSR_DATA_W'(cost_ff[idx]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= tlc_pkg::COST_RESET;
      end else if (psel && penable && pwrite && idx_ok) begin
         cost_ff[idx] <= pwdata[tlc_pkg::COST_W-1:0];
      end
   end

endmodule

[sv/tlc_ctrl.sv]
// ----------------------------------------------------------------------------
// tlc_ctrl
// Sequencer for lookups, block moves and the final word access.
// ----------------------------------------------------------------------------
module tlc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tlc_pkg::status_type  st,
   output tlc_pkg::cmd_type     cmd
);

   tlc_pkg::state_type state_ff, state_in;
   logic               op_wr_ff, op_wr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlc_pkg::ST_CLEAR;
         op_wr_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_wr_ff <= op_wr_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_wr_in  = op_wr_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.l2_wr = op_wr_ff;
      unique case (state_ff)
         tlc_pkg::ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (st.clr_done) state_in = tlc_pkg::ST_IDLE;
         end
         tlc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = tlc_pkg::ST_L1_CHK;
            end
         end
         tlc_pkg::ST_L1_CHK: begin
            if (st.l1_hit) begin
               state_in = tlc_pkg::ST_ACC;
            end else begin
               op_wr_in = st.l1_vdirty;
               state_in = tlc_pkg::ST_L2_LOOK;
            end
         end
         tlc_pkg::ST_L2_LOOK: begin
            cmd.l2_look = 1'b1;
            state_in    = tlc_pkg::ST_L2_CHK;
         end
         tlc_pkg::ST_L2_CHK: begin
            cmd.l2_chk = 1'b1;
            priority if (st.l2_hit)    state_in = tlc_pkg::ST_L2_XFER;
            else if (st.l2_vdirty)     state_in = tlc_pkg::ST_L2_EVICT;
            else                       state_in = tlc_pkg::ST_L2_FETCH;
         end
         tlc_pkg::ST_L2_EVICT: begin
            cmd.copy      = 1'b1;
            cmd.copy_kind = tlc_pkg::CP_EVICT;
            if (st.copy_last) begin
               cmd.add_cost = 1'b1;
               cmd.cost_sel = tlc_pkg::COST_MAIN_WR;
               state_in     = tlc_pkg::ST_L2_FETCH;
            end
         end
         tlc_pkg::ST_L2_FETCH: begin
            cmd.copy      = 1'b1;
            cmd.copy_kind = tlc_pkg::CP_FETCH;
            if (st.copy_last) begin
               cmd.add_cost     = 1'b1;
               cmd.cost_sel     = tlc_pkg::COST_MAIN_RD;
               cmd.l2_fill_meta = 1'b1;
               state_in         = tlc_pkg::ST_L2_XFER;
            end
         end
         tlc_pkg::ST_L2_XFER: begin
            cmd.copy      = 1'b1;
            cmd.copy_kind = op_wr_ff ? tlc_pkg::CP_WB : tlc_pkg::CP_FILL;
            if (st.copy_last) begin
               cmd.add_cost = 1'b1;
               cmd.cost_sel = op_wr_ff ? tlc_pkg::COST_L2_WR : tlc_pkg::COST_L2_RD;
               state_in     = tlc_pkg::ST_L2_DONE;
            end
         end
         tlc_pkg::ST_L2_DONE: begin
            cmd.l2_done = 1'b1;
            if (op_wr_ff) begin
               op_wr_in = 1'b0;
               state_in = tlc_pkg::ST_L2_LOOK;
            end else begin
               state_in = tlc_pkg::ST_ACC;
            end
         end
         tlc_pkg::ST_ACC: begin
            cmd.acc      = 1'b1;
            cmd.add_cost = 1'b1;
            cmd.cost_sel = st.mode ? tlc_pkg::COST_L1_WR : tlc_pkg::COST_L1_RD;
            state_in     = tlc_pkg::ST_FINISH;
         end
         tlc_pkg::ST_FINISH: begin
            if (st.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = tlc_pkg::ST_IDLE;
            end
         end
         default: state_in = tlc_pkg::ST_CLEAR;
      endcase
   end

endmodule

[sv/tlc_dpath.sv]
// ----------------------------------------------------------------------------
// tlc_dpath
// Tag and data memories of both levels, backing store, block mover,
// time accumulator and output register.
// ----------------------------------------------------------------------------
module tlc_dpath #(
   parameter int L1_LINES    = tlc_pkg::L1_LINES_DEF,
   parameter int L2_SETS     = tlc_pkg::L2_SETS_DEF,
   parameter int BLOCK_BYTES = tlc_pkg::BLOCK_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlc_pkg::req_type       req_data,
   input  tlc_pkg::cmd_type       cmd,
   output tlc_pkg::status_type    st,
   input  tlc_pkg::cost_vec_type  costs,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tlc_pkg::rsp_type       rsp_data
);

   localparam int AB    = tlc_pkg::ADDR_BITS;
   localparam int DW    = tlc_pkg::DATA_W;
   localparam int TW    = tlc_pkg::TIME_W;
   localparam int WOFF  = $clog2(tlc_pkg::WORD_BYTES);
   localparam int BW    = BLOCK_BYTES / tlc_pkg::WORD_BYTES;
   localparam int BWB   = $clog2(BW);
   localparam int OFFB  = $clog2(BLOCK_BYTES);
   localparam int L1B   = $clog2(L1_LINES);
   localparam int L2B   = $clog2(L2_SETS);
   localparam int BNB   = AB - OFFB;
   localparam int L1TB  = (BNB > L1B) ? BNB - L1B : 1;
   localparam int L2TB  = (BNB > L2B) ? BNB - L2B : 1;
   localparam int AXB   = BNB + L1B + L2B;
   localparam int STB   = AB - WOFF;
   localparam int STORE_WORDS = 1 << STB;
   localparam int CLR_N0 = (STORE_WORDS > L2_SETS) ? STORE_WORDS : L2_SETS;
   localparam int CLR_N  = (CLR_N0 > L1_LINES) ? CLR_N0 : L1_LINES;
   localparam int CLB   = $clog2(CLR_N);
   localparam int L1MW  = L1TB + 2;
   localparam int L2EW  = L2TB + 2;
   localparam int L2RW  = 2 * L2EW + 1;
   localparam int E0_HI = L2EW;
   localparam int E1_HI = 2 * L2EW;
   localparam int E1_LO = L2EW + 1;
   localparam logic [BWB:0] CP_LAST = (BWB + 1)'(BW);

   // request, control and output registers
   logic          mode_ff;
   logic [AB-1:0] addr_ff;
   logic [DW-1:0] wdata_ff;
   logic [TW-1:0] time_ff;
   logic          l2_hit_ff;
   logic [CLB-1:0] clr_cnt_ff;
   logic [BWB:0]  cp_cnt_ff;
   logic [BNB-1:0] op_blk_ff;
   logic [L2RW-1:0] row_ff;
   logic          way_ff;
   logic          rsp_valid_ff;
   tlc_pkg::rsp_type rsp_ff;

   // request decode
   logic [BNB-1:0]  blk;
   logic [AXB-1:0]  blk_x, blk_sh1, acc_x;
   logic [L1B-1:0]  line, acc_line;
   logic [L1TB-1:0] tag1;
   logic [BWB-1:0]  word;

   assign blk      = addr_ff[AB-1:OFFB];
   assign blk_x    = AXB'(blk);
   assign blk_sh1  = blk_x >> L1B;
   assign line     = blk_x[L1B-1:0];
   assign tag1     = blk_sh1[L1TB-1:0];
   assign word     = addr_ff[WOFF +: BWB];
   assign acc_x    = AXB'(req_data.address[AB-1:OFFB]);
   assign acc_line = acc_x[L1B-1:0];

   // L1 tags
   logic [L1MW-1:0] l1_meta_mem [L1_LINES];
   logic [L1MW-1:0] l1_meta_q, l1_meta_new;
   logic            m_valid, m_dirty, l1_hit_now;
   logic [L1TB-1:0] m_tag;
   logic [AXB-1:0]  vx1;
   logic [BNB-1:0]  v1_blk;

   assign m_valid     = l1_meta_q[L1MW-1];
   assign m_dirty     = l1_meta_q[L1MW-2];
   assign m_tag       = l1_meta_q[L1TB-1:0];
   assign l1_hit_now  = m_valid && (m_tag == tag1);
   assign l1_meta_new = {1'b1, mode_ff | (l1_hit_now & m_dirty), tag1};
   assign vx1         = (AXB'(m_tag) << L1B) | AXB'(line);
   assign v1_blk      = vx1[BNB-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         l1_meta_mem[clr_cnt_ff[L1B-1:0]] <= '0;
      end else if (cmd.acc) begin
         l1_meta_mem[line] <= l1_meta_new;
      end
      if (cmd.accept) begin
         l1_meta_q <= l1_meta_mem[acc_line];
      end
   end

   // L2 tags, one row per set: way 1, way 0, lru
   logic [L2RW-1:0] l2_meta_mem [L2_SETS];
   logic [L2RW-1:0] row_q, row_fill, row_done;
   logic [BNB-1:0]  look_blk;
   logic [AXB-1:0]  look_x, opx, op_sh, vx2;
   logic [L2B-1:0]  look_set, op_set;
   logic [L2TB-1:0] op_tag, w_tag;
   logic [L2EW-1:0] e0, e1, ev, w_ent, ent_new, ent_done;
   logic            hit0, hit1, l2_hit_now, way_now;
   logic [BNB-1:0]  v2_blk;

   assign look_blk   = cmd.l2_wr ? v1_blk : blk;
   assign look_x     = AXB'(look_blk);
   assign look_set   = look_x[L2B-1:0];
   assign opx        = AXB'(op_blk_ff);
   assign op_sh      = opx >> L2B;
   assign op_set     = opx[L2B-1:0];
   assign op_tag     = op_sh[L2TB-1:0];
   assign e0         = row_q[E0_HI:1];
   assign e1         = row_q[E1_HI:E1_LO];
   assign hit0       = e0[L2EW-1] && (e0[L2TB-1:0] == op_tag);
   assign hit1       = e1[L2EW-1] && (e1[L2TB-1:0] == op_tag);
   assign l2_hit_now = hit0 || hit1;
   assign way_now    = hit0 ? 1'b0 : (hit1 ? 1'b1 : row_q[0]);
   assign ev         = way_now ? e1 : e0;
   assign w_ent      = way_ff ? row_ff[E1_HI:E1_LO] : row_ff[E0_HI:1];
   assign w_tag      = w_ent[L2TB-1:0];
   assign ent_new    = {1'b1, 1'b0, op_tag};
   assign ent_done   = {w_ent[L2EW-1], w_ent[L2EW-2] | cmd.l2_wr, w_tag};
   assign vx2        = (AXB'(w_tag) << L2B) | AXB'(op_set);
   assign v2_blk     = vx2[BNB-1:0];

   always_comb begin
      row_fill = row_ff;
      row_done = row_ff;
      if (way_ff) begin
         row_fill[E1_HI:E1_LO] = ent_new;
         row_done[E1_HI:E1_LO] = ent_done;
      end else begin
         row_fill[E0_HI:1] = ent_new;
         row_done[E0_HI:1] = ent_done;
      end
      row_done[0] = ~way_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         l2_meta_mem[clr_cnt_ff[L2B-1:0]] <= '0;
      end else if (cmd.l2_done) begin
         l2_meta_mem[op_set] <= row_done;
      end
      if (cmd.l2_look) begin
         row_q <= l2_meta_mem[look_set];
      end
   end

   // block mover
   logic [BWB-1:0] rw, ww;
   logic [BWB:0]   cnt_m1;
   logic           cp_rd, cp_wr, copy_last;

   assign rw        = cp_cnt_ff[BWB-1:0];
   assign cnt_m1    = cp_cnt_ff - 1'b1;
   assign ww        = cnt_m1[BWB-1:0];
   assign copy_last = cp_cnt_ff == CP_LAST;
   assign cp_rd     = cmd.copy && !copy_last;
   assign cp_wr     = cmd.copy && (cp_cnt_ff != '0);

   // data memories
   logic [DW-1:0] l1_data [L1_LINES * BW];
   logic [DW-1:0] l2_data [L2_SETS * 2 * BW];
   logic [DW-1:0] store   [STORE_WORDS];
   logic [DW-1:0] l1_q, l2_q, st_q;

   logic                l1_rd_en, l1_wr_en, l2_rd_en, l2_wr_en, st_rd_en, st_wr_en;
   logic [L1B+BWB-1:0]  l1_rd_addr, l1_wr_addr;
   logic [L2B+BWB:0]    l2_rd_addr, l2_wr_addr;
   logic [STB-1:0]      st_rd_addr, st_wr_addr;
   logic [DW-1:0]       l1_wr_data, l2_wr_data, st_wr_data;

   assign l1_rd_en   = (cmd.acc && !mode_ff) || (cp_rd && cmd.copy_kind == tlc_pkg::CP_WB);
   assign l1_rd_addr = cmd.acc ? {line, word} : {line, rw};
   assign l1_wr_en   = (cmd.acc && mode_ff) || (cp_wr && cmd.copy_kind == tlc_pkg::CP_FILL);
   assign l1_wr_addr = cmd.acc ? {line, word} : {line, ww};
   assign l1_wr_data = cmd.acc ? wdata_ff : l2_q;

   assign l2_rd_en   = cp_rd && (cmd.copy_kind == tlc_pkg::CP_EVICT ||
                                 cmd.copy_kind == tlc_pkg::CP_FILL);
   assign l2_rd_addr = {op_set, way_ff, rw};
   assign l2_wr_en   = cp_wr && (cmd.copy_kind == tlc_pkg::CP_FETCH ||
                                 cmd.copy_kind == tlc_pkg::CP_WB);
   assign l2_wr_addr = {op_set, way_ff, ww};
   assign l2_wr_data = (cmd.copy_kind == tlc_pkg::CP_FETCH) ? st_q : l1_q;

   assign st_rd_en   = cp_rd && cmd.copy_kind == tlc_pkg::CP_FETCH;
   assign st_rd_addr = {op_blk_ff, rw};
   assign st_wr_en   = cmd.clr || (cp_wr && cmd.copy_kind == tlc_pkg::CP_EVICT);
   assign st_wr_addr = cmd.clr ? clr_cnt_ff[STB-1:0] : {v2_blk, ww};
   assign st_wr_data = cmd.clr ? '0 : l2_q;

   always_ff @(posedge clock) begin
      if (l1_wr_en) l1_data[l1_wr_addr] <= l1_wr_data;
      if (l1_rd_en) l1_q <= l1_data[l1_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (l2_wr_en) l2_data[l2_wr_addr] <= l2_wr_data;
      if (l2_rd_en) l2_q <= l2_data[l2_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (st_wr_en) store[st_wr_addr] <= st_wr_data;
      if (st_rd_en) st_q <= store[st_rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         l2_hit_ff    <= 1'b0;
         clr_cnt_ff   <= '0;
         cp_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.add_cost) time_ff <= time_ff + TW'(costs[cmd.cost_sel]);
         if (cmd.accept) l2_hit_ff <= 1'b0;
         else if (cmd.l2_chk) l2_hit_ff <= l2_hit_now;
         if (cmd.clr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.copy) cp_cnt_ff <= copy_last ? '0 : cp_cnt_ff + 1'b1;
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_data.mode;
         addr_ff  <= req_data.address;
         wdata_ff <= req_data.write_data;
      end
      if (cmd.l2_look) op_blk_ff <= look_blk;
      if (cmd.l2_chk) begin
         row_ff <= row_q;
         way_ff <= way_now;
      end else if (cmd.l2_fill_meta) begin
         row_ff <= row_fill;
      end
      if (cmd.finish) begin
         rsp_ff.read_data    <= mode_ff ? '0 : l1_q;
         rsp_ff.l1_hit       <= l1_hit_now;
         rsp_ff.l2_hit       <= l2_hit_ff;
         rsp_ff.elapsed_time <= time_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign st.clr_done  = &clr_cnt_ff;
   assign st.mode      = mode_ff;
   assign st.l1_hit    = l1_hit_now;
   assign st.l1_vdirty = m_valid && m_dirty;
   assign st.l2_hit    = l2_hit_now;
   assign st.l2_vdirty = ev[L2EW-1] && ev[L2EW-2];
   assign st.copy_last = copy_last;
   assign st.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

[sv/two_level_writeback_cache.sv]
// ----------------------------------------------------------------------------
// two_level_writeback_cache
// Direct-mapped L1 over a two-way LRU L2 over a word store, all write-back.
//
// channel   dir     ports
// req       in      req_valid, req_stall, req_data
// rsp       out     rsp_valid, rsp_stall, rsp_data
// csr       in/out  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one item at a time; an L1 hit goes from acceptance through L1_CHK, ACC and
// FINISH to rsp_valid; each block move (store or L2 victim out, store fetch,
// L1/L2 transfer) goes word by word through one memory port per level
// a miss costs 1 to 6 block moves plus the L2 lookup and check states
// after reset a clearing pass over max(store words, L2 sets, L1 lines)
// addresses (store and both tag memories) runs with req_stall high
// the next item is taken while a result waits under rsp_stall
// ----------------------------------------------------------------------------
module two_level_writeback_cache #(
   parameter int L1_LINES    = tlc_pkg::L1_LINES_DEF,
   parameter int L2_SETS     = tlc_pkg::L2_SETS_DEF,
   parameter int BLOCK_BYTES = tlc_pkg::BLOCK_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tlc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tlc_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tlc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tlc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tlc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   tlc_pkg::cmd_type      cmd;
   tlc_pkg::status_type   st;
   tlc_pkg::cost_vec_type costs;

   tlc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .costs   (costs)
   );

   tlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   tlc_dpath #(
      .L1_LINES    (L1_LINES),
      .L2_SETS     (L2_SETS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .costs     (costs),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/tlc_checker.sv]
// ----------------------------------------------------------------------------
// tlc_checker
// Port-level checks of the cache, bound to the top level.
// ----------------------------------------------------------------------------
module tlc_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tlc_pkg::rsp_type rsp_data
);

   logic       in_acc, out_acc;
   logic [1:0] pend_ff, pend_in;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      priority if (in_acc && !out_acc) pend_in = pend_ff + 2'd1;
      else if (!in_acc && out_acc)     pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else       pend_ff <= pend_in;
   end

   // items in flight: one in work and one in the output register
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd2)
      else $error("more than two items in flight");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.l1_hit && rsp_data.l2_hit))
      else $error("l2 hit flagged on an l1 hit");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("item taken during clearing pass");

endmodule

bind two_level_writeback_cache tlc_checker u_tlc_checker (.*);

[dv/two_level_writeback_cache_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_writeback_cache_test
// Checks the two-level cache against a built-in cache predictor: directed
// hits, misses, dirty evictions at both levels and address truncation, then
// random accesses over a few hot lines under changing access costs and
// random idling on both channels.
// ----------------------------------------------------------------------------
module two_level_writeback_cache_test;

   localparam bit MODE_RD = 1'b0;
   localparam bit MODE_WR = 1'b1;
   localparam int STALL_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tlc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   tlc_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [tlc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [tlc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [tlc_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   tlc_pkg::req_type pending_reqs[$];
   tlc_pkg::rsp_type expected_rsps[$];
   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int quiet_cycles = 0;

   // predictor state
   bit [31:0] mem_word[262144];
   bit [31:0] l1_word[4096];
   bit l1_v[256];
   bit l1_d[256];
   bit [5:0] l1_t[256];
   bit [31:0] l2_word[16384];
   bit l2_v[1024];
   bit l2_d[1024];
   bit [4:0] l2_t[1024];
   bit l2_lru[512];
   bit [31:0] time_sum = 0;
   bit [9:0] cost_of[6] = '{10'd1, 10'd1, 10'd4, 10'd4, 10'd100, 10'd100};

   two_level_writeback_cache i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   task automatic store_xfer(input bit [19:0] baddr, input int slot, input bit wr);
      int b;
      b = baddr[19:2];
      for (int i = 0; i < 16; i++) begin
         if (wr) mem_word[b + i] = l2_word[slot * 16 + i];
         else l2_word[slot * 16 + i] = mem_word[b + i];
      end
      time_sum += wr ? cost_of[tlc_pkg::COST_MAIN_WR] : cost_of[tlc_pkg::COST_MAIN_RD];
   endtask

   task automatic l2_xfer(input bit [19:0] baddr, input int line, input bit wr,
                          output bit hit);
      bit [8:0] set;
      bit [4:0] tg;
      int way;
      int slot;
      set = baddr[14:6];
      tg = baddr[19:15];
      hit = 0;
      way = 0;
      for (int w = 0; w < 2; w++) begin
         if (!hit && l2_v[set * 2 + w] && l2_t[set * 2 + w] == tg) begin
            hit = 1;
            way = w;
         end
      end
      if (!hit) begin
         way = l2_lru[set];
         slot = set * 2 + way;
         if (l2_v[slot] && l2_d[slot]) store_xfer({l2_t[slot], set, 6'd0}, slot, 1);
         store_xfer(baddr, slot, 0);
         l2_v[slot] = 1;
         l2_t[slot] = tg;
         l2_d[slot] = 0;
      end
      slot = set * 2 + way;
      for (int i = 0; i < 16; i++) begin
         if (wr) l2_word[slot * 16 + i] = l1_word[line * 16 + i];
         else l1_word[line * 16 + i] = l2_word[slot * 16 + i];
      end
      if (wr) begin
         l2_d[slot] = 1;
         time_sum += cost_of[tlc_pkg::COST_L2_WR];
      end else begin
         time_sum += cost_of[tlc_pkg::COST_L2_RD];
      end
      l2_lru[set] = ~way[0];
   endtask

   task automatic cache_access(input tlc_pkg::req_type r, output tlc_pkg::rsp_type res);
      bit [7:0] line;
      bit [5:0] tg;
      int widx;
      bit l2h;
      bit dummy;
      line = r.address[13:6];
      tg = r.address[19:14];
      widx = line * 16 + r.address[5:2];
      res = '0;
      if (l1_v[line] && l1_t[line] == tg) begin
         res.l1_hit = 1;
      end else begin
         if (l1_v[line] && l1_d[line]) l2_xfer({l1_t[line], line, 6'd0}, line, 1, dummy);
         l2_xfer({r.address[19:6], 6'd0}, line, 0, l2h);
         res.l2_hit = l2h;
         l1_v[line] = 1;
         l1_t[line] = tg;
         l1_d[line] = 0;
      end
      if (r.mode == MODE_WR) begin
         l1_word[widx] = r.write_data;
         l1_d[line] = 1;
         time_sum += cost_of[tlc_pkg::COST_L1_WR];
      end else begin
         res.read_data = l1_word[widx];
         time_sum += cost_of[tlc_pkg::COST_L1_RD];
      end
      res.elapsed_time = time_sum;
   endtask

   // driver
   always @(posedge clock) begin
      tlc_pkg::rsp_type res;
      if (req_valid && !req_stall) begin
         cache_access(req_data, res);
         expected_rsps.push_back(res);
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      tlc_pkg::rsp_type exp_rsp;
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if (rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected item: actual %h", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.read_data !== exp_rsp.read_data) begin
               $display("%0t read_data: expected %h actual %h", $time,
                        exp_rsp.read_data, rsp_data.read_data);
               errors++;
            end
            if (rsp_data.l1_hit !== exp_rsp.l1_hit) begin
               $display("%0t l1_hit: expected %b actual %b", $time,
                        exp_rsp.l1_hit, rsp_data.l1_hit);
               errors++;
            end
            if (rsp_data.l2_hit !== exp_rsp.l2_hit) begin
               $display("%0t l2_hit: expected %b actual %b", $time,
                        exp_rsp.l2_hit, rsp_data.l2_hit);
               errors++;
            end
            if (rsp_data.elapsed_time !== exp_rsp.elapsed_time) begin
               $display("%0t elapsed_time: expected %0d actual %0d", $time,
                        exp_rsp.elapsed_time, rsp_data.elapsed_time);
               errors++;
            end
         end
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input int idx, input bit [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= tlc_pkg::CSR_ADDR_W'(idx * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx < tlc_pkg::NUM_COSTS) cost_of[idx] = value[9:0];
   endtask

   task automatic set_costs(input int style);
      bit [31:0] v;
      for (int i = 0; i < tlc_pkg::NUM_COSTS; i++) begin
         case (style)
            0: v = 32'h3FF;
            1: v = 32'h0;
            default: v = $urandom;
         endcase
         csr_write(i, v);
      end
      // out of range index is ignored
      csr_write(7, $urandom);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_req(input bit m, input bit [19:0] a, input bit [31:0] d);
      tlc_pkg::req_type r;
      r.mode = m;
      r.address = a;
      r.write_data = d;
      pending_reqs.push_back(r);
   endtask

   task automatic push_random(input int count);
      bit [19:0] a;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 8) begin
            // hot lines with a few tags so both levels evict often
            a = 20'($urandom);
            a[19:14] = 6'($urandom_range(5));
            a[13:6] = 8'($urandom_range(3) * 85);
         end else begin
            a = 20'($urandom);
         end
         push_req(1'($urandom_range(1)), a, $urandom);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset costs, extremes, dirty evictions in both levels
      push_req(MODE_RD, 20'h00000, 32'h0);
      push_req(MODE_WR, 20'h00000, 32'hFFFFFFFF);
      push_req(MODE_RD, 20'h00003, 32'hFFFFFFFF);
      push_req(MODE_WR, 20'hFFFFF, 32'h0);
      push_req(MODE_RD, 20'hFFFFC, 32'h0);
      push_req(MODE_WR, 20'h0003C, 32'hA5A5A5A5);
      push_req(MODE_RD, 20'h04000, 32'h0);
      push_req(MODE_RD, 20'h00000, 32'h0);
      push_req(MODE_WR, 20'h04004, 32'h5A5A5A5A);
      push_req(MODE_RD, 20'h08000, 32'h0);
      push_req(MODE_WR, 20'h10008, 32'h12345678);
      push_req(MODE_RD, 20'h18000, 32'h0);
      push_req(MODE_RD, 20'h00000, 32'h0);
      push_req(MODE_RD, 20'h04004, 32'h0);
      push_req(MODE_RD, 20'h10008, 32'h0);
      push_req(MODE_RD, 20'h0003C, 32'h0);
      drain();

      set_costs(0);
      send_idle = 36;
      recv_idle = 50;
      push_random(530);
      drain();

      set_costs(1);
      send_idle = 50;
      recv_idle = 36;
      push_random(530);
      drain();

      set_costs(2);
      send_idle = 0;
      recv_idle = 0;
      push_random(540);
      drain();

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
